[rtl/rhc_pkg.sv]
// shared types, constants and sector codes for the rgb to hsv converter
package rhc_pkg;

  // channel and result widths
  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 15;

  // restoring divider: one quotient bit per pipeline step
  localparam int unsigned DivSteps = 12;
  localparam int unsigned RemW     = 20;
  localparam int unsigned DsrW     = ChanW + DivSteps - 1;

  // hue scaling: degrees times 64
  localparam logic [16:0] HueFull     = 17'd23040;
  localparam logic [14:0] BaseRedOff   = 15'd0;
  localparam logic [14:0] BaseGreenOff = 15'd7680;
  localparam logic [14:0] BaseBlueOff  = 15'd15360;

  // sector that holds the largest channel
  typedef enum logic [1:0] {
    BASE_RED,
    BASE_GREEN,
    BASE_BLUE
  } base_e;

  // one input item
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // one result item
  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] value;
  } hsv_t;

  // sector result after the first stage
  typedef struct packed {
    logic [ChanW-1:0] mx;
    logic [ChanW-1:0] mn;
    logic [ChanW:0]   phase;
    base_e            base;
  } sector_t;

  // state of one restoring divider
  typedef struct packed {
    logic [RemW-1:0]     rem;
    logic [DsrW-1:0]     dsr;
    logic [DivSteps-1:0] quo;
  } div_t;

  // side information that rides along the divider stages
  typedef struct packed {
    base_e            base;
    logic             neg;
    logic             hue_zero;
    logic             sat_zero;
    logic [ChanW-1:0] value;
  } side_t;

  // payload of one divider stage
  typedef struct packed {
    div_t  hue;
    div_t  sat;
    side_t side;
  } divp_t;

endpackage

[rtl/rhc_sector.sv]
// sector pick and divider setup, two register stages
module rhc_sector import rhc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] en_i,
  input  logic       valid_i,
  input  pixel_t     pixel_i,
  output logic [1:0] valid_o,
  output divp_t      data_o
);

  sector_t sec_d, sec_q;
  divp_t   div_d, div_q;
  logic    v0_q, v1_q;

  logic [ChanW-1:0] d_val;
  logic [ChanW-1:0] mag;
  logic [RemW-1:0]  hue_num;
  logic [RemW-1:0]  sat_num;

  // largest channel picks the sector, ties go blue first, then green, then red
  always_comb begin
    sec_d = '0;
    if (pixel_i.red > pixel_i.green) begin
      if (pixel_i.red > pixel_i.blue) begin
        sec_d.mx    = pixel_i.red;
        sec_d.mn    = (pixel_i.green < pixel_i.blue) ? pixel_i.green : pixel_i.blue;
        sec_d.phase = {1'b0, pixel_i.green} - {1'b0, pixel_i.blue};
        sec_d.base  = BASE_RED;
      end else begin
        sec_d.mx    = pixel_i.blue;
        sec_d.mn    = pixel_i.green;
        sec_d.phase = {1'b0, pixel_i.red} - {1'b0, pixel_i.green};
        sec_d.base  = BASE_BLUE;
      end
    end else begin
      if (pixel_i.green > pixel_i.blue) begin
        sec_d.mx    = pixel_i.green;
        sec_d.mn    = (pixel_i.red < pixel_i.blue) ? pixel_i.red : pixel_i.blue;
        sec_d.phase = {1'b0, pixel_i.blue} - {1'b0, pixel_i.red};
        sec_d.base  = BASE_GREEN;
      end else begin
        sec_d.mx    = pixel_i.blue;
        sec_d.mn    = pixel_i.red;
        sec_d.phase = {1'b0, pixel_i.red} - {1'b0, pixel_i.green};
        sec_d.base  = BASE_BLUE;
      end
    end
  end

  // chroma, phase magnitude and scaled dividends
  always_comb begin
    d_val   = sec_q.mx - sec_q.mn;
    mag     = sec_q.phase[ChanW] ? ChanW'(-sec_q.phase) : sec_q.phase[ChanW-1:0];
    // 3840 * mag = (mag << 12) - (mag << 8)
    hue_num = ({{(RemW-ChanW){1'b0}}, mag} << 12) - ({{(RemW-ChanW){1'b0}}, mag} << 8);
    // 255 * d = (d << 8) - d
    sat_num = ({{(RemW-ChanW){1'b0}}, d_val} << 8) - {{(RemW-ChanW){1'b0}}, d_val};

    div_d.hue.rem       = hue_num;
    div_d.hue.dsr       = {d_val, {(DivSteps-1){1'b0}}};
    div_d.hue.quo       = '0;
    div_d.sat.rem       = sat_num;
    div_d.sat.dsr       = {sec_q.mx, {(DivSteps-1){1'b0}}};
    div_d.sat.quo       = '0;
    div_d.side.base     = sec_q.base;
    div_d.side.neg      = sec_q.phase[ChanW];
    div_d.side.hue_zero = (d_val == '0);
    div_d.side.sat_zero = (sec_q.mx == '0);
    div_d.side.value    = sec_q.mx;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en_i[0]) v0_q <= valid_i;
      if (en_i[1]) v1_q <= v0_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en_i[0]) sec_q <= sec_d;
    if (en_i[1]) div_q <= div_d;
  end

  assign valid_o = {v1_q, v0_q};
  assign data_o  = div_q;

endmodule

[rtl/rhc_div_stage.sv]
// one restoring division step for hue and saturation
module rhc_div_stage import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  divp_t data_i,
  output logic  valid_o,
  output divp_t data_o
);

  divp_t data_d, data_q;
  logic  valid_q;

  // subtract the aligned divisor if it fits, shift in one quotient bit
  function automatic div_t div_step(input div_t cur);
    div_t nxt;
    logic fits;
    fits    = (cur.rem >= {{(RemW-DsrW){1'b0}}, cur.dsr});
    nxt.rem = fits ? (cur.rem - {{(RemW-DsrW){1'b0}}, cur.dsr}) : cur.rem;
    nxt.dsr = cur.dsr >> 1;
    nxt.quo = {cur.quo[DivSteps-2:0], fits};
    return nxt;
  endfunction

  always_comb begin
    data_d.hue  = div_step(data_i.hue);
    data_d.sat  = div_step(data_i.sat);
    data_d.side = data_i.side;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/rhc_finish.sv]
// hue assembly, zero cases and the output register
module rhc_finish import rhc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  divp_t data_i,
  output logic  valid_o,
  output hsv_t  hsv_o
);

  hsv_t               hsv_d, hsv_q;
  logic               valid_q;
  logic [14:0]        base_off;
  logic signed [16:0] qs;
  logic signed [16:0] sum;
  logic signed [16:0] wrapped;

  // base angle of the sector
  always_comb begin
    unique case (data_i.side.base)
      BASE_RED:   base_off = BaseRedOff;
      BASE_GREEN: base_off = BaseGreenOff;
      BASE_BLUE:  base_off = BaseBlueOff;
      default:    base_off = BaseRedOff;
    endcase
  end

  // signed phase quotient plus base, wrapped into one turn
  always_comb begin
    qs      = $signed({5'b0, data_i.hue.quo});
    sum     = $signed({2'b0, base_off}) + (data_i.side.neg ? -qs : qs);
    wrapped = sum[16] ? (sum + $signed(HueFull)) : sum;

    hsv_d.hue        = data_i.side.hue_zero ? '0 : wrapped[HueW-1:0];
    hsv_d.saturation = data_i.side.sat_zero ? '0 : data_i.sat.quo[ChanW-1:0];
    hsv_d.value      = data_i.side.value;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // output item
  always_ff @(posedge clk_i) begin
    if (en_i) hsv_q <= hsv_d;
  end

  assign valid_o = valid_q;
  assign hsv_o   = hsv_q;

endmodule

[rtl/rgb_to_hsv_converter.sv]
// top level of the rgb to hsv converter pipeline
// Converts one 8-bit RGB pixel per clock into hue (degrees times 64, 0..23039),
// saturation (0..255) and value (0..255). The pipeline holds two stages for
// sector selection and divider setup, twelve stages of a restoring divider
// that produces one quotient bit per stage for hue and saturation side by
// side, and one stage for hue assembly into the output register.
// Throughput is one item per clock; when the output is stalled, empty
// stages keep accepting until the pipeline is full.
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   stall_o,
  input  pixel_t pixel_i,
  output logic   valid_o,
  input  logic   stall_i,
  output hsv_t   hsv_o
);

  logic [1:0]          sec_en;
  logic [1:0]          sec_valid;
  logic [DivSteps-1:0] div_en;
  logic [DivSteps:0]   div_valid;
  divp_t               div_data [DivSteps+1];
  logic                fin_en;

  // advance chain: a stage moves when empty or when its successor moves
  assign fin_en = !valid_o || !stall_i;

  // walk from the output end so each stage sees its successor's enable
  always_comb begin
    for (int k = DivSteps - 1; k >= 0; k--) begin
      if (k == DivSteps - 1) begin
        div_en[k] = !div_valid[k+1] || fin_en;
      end else begin
        div_en[k] = !div_valid[k+1] || div_en[k+1];
      end
    end
  end

  assign sec_en[1] = !sec_valid[1] || div_en[0];
  assign sec_en[0] = !sec_valid[0] || sec_en[1];
  assign stall_o   = !sec_en[0];

  // sector selection and divider setup
  rhc_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (sec_en),
    .valid_i (valid_i),
    .pixel_i (pixel_i),
    .valid_o (sec_valid),
    .data_o  (div_data[0])
  );

  assign div_valid[0] = sec_valid[1];

  // divider steps
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    rhc_div_stage u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (div_en[g]),
      .valid_i (div_valid[g]),
      .data_i  (div_data[g]),
      .valid_o (div_valid[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  // hue assembly and output register
  rhc_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fin_en),
    .valid_i (div_valid[DivSteps]),
    .data_i  (div_data[DivSteps]),
    .valid_o (valid_o),
    .hsv_o   (hsv_o)
  );

  // input side only stalls when the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled while output is free");

  // hue stays within one turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hsv_o.hue <= 15'd23039))
    else $error("hue out of range");

  // black pixel has no hue and no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (hsv_o.value == '0)) |-> ((hsv_o.saturation == '0) && (hsv_o.hue == '0)))
    else $error("black pixel with nonzero hue or saturation");

  // a full pipeline whose output is taken accepts again in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i) |-> !stall_o)
    else $error("pipeline stalled while output is taken");

endmodule
